// ===== rtl/spfm_pkg.sv =====
// Shared types and constants for the slave polling frame master.
`default_nettype none
package spfm_pkg;

  localparam int NUM_SLAVES_DEF = 3;
  localparam int CMDQ_DEPTH     = 2;
  localparam int ADDR_W         = 4;

  localparam logic [15:0] SUB_PERIOD_RST    = 16'd100;
  localparam logic [15:0] REPORT_PERIOD_RST = 16'd10;
  localparam logic [7:0]  LAST_ID_RST       = 8'd3;
  localparam logic [7:0]  POLL_PAYLOAD_RST  = 8'hFD;
  localparam logic [7:0]  POLL_ID_RST       = 8'h01;

  localparam logic [7:0] FRAME_START = 8'hFF;
  localparam logic [7:0] FRAME_END   = 8'hEE;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic PORT_SLAVE  = 1'b0;
  localparam logic PORT_SERVER = 1'b1;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_SUB_PERIOD    = 2'd0;
  localparam logic [1:0] REG_REPORT_PERIOD = 2'd1;
  localparam logic [1:0] REG_LAST_ID       = 2'd2;
  localparam logic [1:0] REG_POLL_PAYLOAD  = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic       port;
    logic [7:0] tx_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] poll_id;
    logic [7:0] payload;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/slave_polling_frame_master.sv =====
// Top level: config registers, front end, command queue and back end.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------
//  item    | push / full        | in_word_t  {operation, rx_byte}
//  result  | empty / pop        | out_word_t {port, tx_byte, last}
//  config  | APB psel/penable   | paddr[3:0], pwdata/prdata 32 bit
//
// One item is taken per cycle while full is low; a received byte or a tick
// is fully handled in the cycle it is accepted. A burst tick queues one
// command; the back end loads it, then sends NUM_SLAVES+7 words, one per
// cycle while pop keeps up. full rises only when the command queue holds
// CMDQ_DEPTH bursts not yet started. Reset is synchronous and restores the
// register defaults; counters, live marks and the queues are cleared.
`default_nettype none
module slave_polling_frame_master
  import spfm_pkg::*;
#(
  parameter int NUM_SLAVES = NUM_SLAVES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire in_word_t          item,
  output logic                   empty,
  input  wire logic              pop,
  output out_word_t              result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CMD_W = $bits(cmd_t) + NUM_SLAVES;

  logic [15:0] sub_period;
  logic [15:0] report_period;
  logic [7:0]  last_slave_id;
  logic [7:0]  poll_payload;

  logic                  accept;
  logic                  trig;
  cmd_t                  front_cmd;
  logic [NUM_SLAVES-1:0] front_live;
  logic [CMD_W-1:0]      q_rdata;
  logic                  q_empty;
  logic                  q_rd;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_period    <= SUB_PERIOD_RST;
      report_period <= REPORT_PERIOD_RST;
      last_slave_id <= LAST_ID_RST;
      poll_payload  <= POLL_PAYLOAD_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SUB_PERIOD:    sub_period    <= pwdata[15:0];
        REG_REPORT_PERIOD: report_period <= pwdata[15:0];
        REG_LAST_ID:       last_slave_id <= pwdata[7:0];
        REG_POLL_PAYLOAD:  poll_payload  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SUB_PERIOD:    prdata = {16'd0, sub_period};
      REG_REPORT_PERIOD: prdata = {16'd0, report_period};
      REG_LAST_ID:       prdata = {24'd0, last_slave_id};
      REG_POLL_PAYLOAD:  prdata = {24'd0, poll_payload};
      default:           prdata = '0;
    endcase
  end

  spfm_front #(
    .NUM_SLAVES(NUM_SLAVES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .sub_period    (sub_period),
    .report_period (report_period),
    .last_slave_id (last_slave_id),
    .poll_payload  (poll_payload),
    .trig          (trig),
    .cmd           (front_cmd),
    .live_snap     (front_live)
  );

  spfm_cmdq #(
    .W     (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (trig),
    .wdata ({front_live, front_cmd}),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (full),
    .empty (q_empty)
  );

  spfm_back #(
    .NUM_SLAVES(NUM_SLAVES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (q_rdata[$bits(cmd_t)-1:0]),
    .cmd_live  (q_rdata[CMD_W-1:$bits(cmd_t)]),
    .cmd_pop   (q_rd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
`default_nettype wire

// ===== rtl/spfm_front.sv =====
// Front end: frame receiver, tick counters and burst trigger.
`default_nettype none
module spfm_front
  import spfm_pkg::*;
#(
  parameter int NUM_SLAVES = NUM_SLAVES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire in_word_t              item,
  input  wire logic [15:0]           sub_period,
  input  wire logic [15:0]           report_period,
  input  wire logic [7:0]            last_slave_id,
  input  wire logic [7:0]            poll_payload,
  output logic                       trig,
  output cmd_t                       cmd,
  output logic [NUM_SLAVES-1:0]      live_snap
);

  logic [15:0]           tick_count;
  logic [15:0]           interval_count;
  logic [7:0]            poll_id;
  logic [2:0]            rx_count;
  logic [7:0]            rx_frame [4];
  logic [NUM_SLAVES-1:0] slave_live;

  logic [15:0] tick_inc;
  logic [15:0] interval_inc;
  logic        tick_wrap;
  logic        interval_wrap;
  logic [7:0]  sel_id;
  logic        frame_ok;
  logic        is_tick;
  logic        is_rx;

  assign is_tick       = accept && (item.operation == OP_TICK);
  assign is_rx         = accept && (item.operation == OP_RX);
  assign tick_inc      = tick_count + 16'd1;
  assign interval_inc  = interval_count + 16'd1;
  assign tick_wrap     = tick_inc >= sub_period;
  assign interval_wrap = interval_inc >= report_period;
  assign sel_id        = (poll_id > last_slave_id) ? POLL_ID_RST : poll_id;

  assign frame_ok = (rx_frame[0] == FRAME_START) && (rx_frame[3] == ~rx_frame[2]) &&
                    (item.rx_byte == FRAME_END);

  assign trig          = is_tick && tick_wrap && interval_wrap;
  assign cmd.poll_id   = sel_id;
  assign cmd.payload   = poll_payload;
  assign live_snap     = slave_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      interval_count <= '0;
      poll_id        <= POLL_ID_RST;
    end else if (is_tick) begin
      if (!tick_wrap) begin
        tick_count <= tick_inc;
      end else begin
        tick_count <= '0;
        if (!interval_wrap) begin
          interval_count <= interval_inc;
        end else begin
          interval_count <= '0;
          poll_id        <= sel_id + 8'd1;
        end
      end
    end
  end

  // frame bytes are all rewritten before the check, so no clear is needed
  always_ff @(posedge clk) begin
    if (is_rx && rx_count != 3'd4) begin
      rx_frame[rx_count[1:0]] <= item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count   <= '0;
      slave_live <= '0;
    end else if (is_rx) begin
      if (rx_count != 3'd4) begin
        rx_count <= rx_count + 3'd1;
      end else begin
        rx_count <= '0;
        if (frame_ok) begin
          for (int i = 0; i < NUM_SLAVES; i++) begin
            if (rx_frame[1] == 8'(i + 1)) begin
              slave_live[i] <= 1'b1;
            end
          end
        end
      end
    end
  end

  a_rx_count_range: assert property (@(posedge clk) disable iff (rst)
    rx_count <= 3'd4) else $error("rx byte count out of range");

  a_trig_on_tick: assert property (@(posedge clk) disable iff (rst)
    trig |-> (accept && item.operation == OP_TICK))
    else $error("burst trigger without a tick");

endmodule
`default_nettype wire

// ===== rtl/spfm_cmdq.sv =====
// Small command queue between front and back.
`default_nettype none
module spfm_cmdq
  import spfm_pkg::*;
#(
  parameter int W     = 16,
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wdata,
  input  wire logic         rd,
  output logic [W-1:0]      rdata,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full)) else $error("command queue overflow");

endmodule
`default_nettype wire

// ===== rtl/spfm_back.sv =====
// Back end: plays one burst command out as server and poll frame words.
`default_nettype none
module spfm_back
  import spfm_pkg::*;
#(
  parameter int NUM_SLAVES = NUM_SLAVES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  input  wire cmd_t                  cmd,
  input  wire logic [NUM_SLAVES-1:0] cmd_live,
  output logic                       cmd_pop,
  output logic                       empty,
  input  wire logic                  pop,
  output out_word_t                  result
);

  localparam int BURST_LEN = NUM_SLAVES + 7;
  localparam int CNT_W     = $clog2(BURST_LEN);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  cmd_t                  cur;
  logic [NUM_SLAVES-1:0] live_sr;
  logic                  out_valid;
  logic                  emit;
  logic                  in_live;
  out_word_t             word;

  assign cmd_pop = !busy && cmd_valid;
  assign emit    = busy && (!out_valid || pop);
  assign empty   = !out_valid;
  assign in_live = (cnt != '0) && (cnt <= CNT_W'(NUM_SLAVES));

  always_comb begin
    word.port    = PORT_SLAVE;
    word.tx_byte = FRAME_END;
    word.last    = 1'b0;
    if (cnt == '0) begin
      word.port    = PORT_SERVER;
      word.tx_byte = FRAME_START;
    end else if (in_live) begin
      word.port    = PORT_SERVER;
      word.tx_byte = {7'd0, live_sr[0]};
    end else if (cnt == CNT_W'(NUM_SLAVES + 1)) begin
      word.port    = PORT_SERVER;
      word.tx_byte = FRAME_END;
    end else if (cnt == CNT_W'(NUM_SLAVES + 2)) begin
      word.tx_byte = FRAME_START;
    end else if (cnt == CNT_W'(NUM_SLAVES + 3)) begin
      word.tx_byte = cur.poll_id;
    end else if (cnt == CNT_W'(NUM_SLAVES + 4)) begin
      word.tx_byte = cur.payload;
    end else if (cnt == CNT_W'(NUM_SLAVES + 5)) begin
      word.tx_byte = ~cur.payload;
    end else begin
      word.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur     <= cmd;
      live_sr <= cmd_live;
    end else if (emit && in_live) begin
      live_sr <= live_sr >> 1;
    end
    if (emit) begin
      result <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (emit) begin
        if (cnt == CNT_W'(BURST_LEN - 1)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + CNT_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt < CNT_W'(BURST_LEN))) else $error("burst index out of range");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.last) |-> (result.port == PORT_SLAVE && result.tx_byte == FRAME_END))
    else $error("last flag on a word other than the poll end byte");

endmodule
`default_nettype wire

// ===== sim/spfm_tx_check.sv =====
// Burst predictor and word-by-word compare for the slave polling frame master.
`timescale 1ns / 1ps
module spfm_tx_check
  import spfm_pkg::*;
#(
  parameter int NUM_SLAVES = NUM_SLAVES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  in_word_t          item,
  input  logic              empty,
  input  logic              pop,
  input  out_word_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                errors,
  output int                pending
);

  localparam int SHOW_MAX = 100;

  logic [15:0]           sub_len, steps_per_burst, tick_cnt, step_cnt;
  logic [7:0]            top_id, payload, next_id;
  int                    rx_cnt;
  logic [7:0]            frame [4];
  logic [NUM_SLAVES-1:0] live;
  out_word_t             tx_q [$];

  function automatic out_word_t tx_word(input logic p, input logic [7:0] b, input logic l);
    out_word_t w;
    w.port = p;
    w.tx_byte = b;
    w.last = l;
    return w;
  endfunction

  task queue_burst;
    int i;
    tx_q.push_back(tx_word(PORT_SERVER, FRAME_START, 1'b0));
    for (i = 0; i < NUM_SLAVES; i++)
      tx_q.push_back(tx_word(PORT_SERVER, {7'd0, live[i]}, 1'b0));
    tx_q.push_back(tx_word(PORT_SERVER, FRAME_END, 1'b0));
    if (next_id > top_id) next_id = POLL_ID_RST;
    tx_q.push_back(tx_word(PORT_SLAVE, FRAME_START, 1'b0));
    tx_q.push_back(tx_word(PORT_SLAVE, next_id, 1'b0));
    tx_q.push_back(tx_word(PORT_SLAVE, payload, 1'b0));
    tx_q.push_back(tx_word(PORT_SLAVE, ~payload, 1'b0));
    tx_q.push_back(tx_word(PORT_SLAVE, FRAME_END, 1'b1));
    next_id = next_id + 8'd1;
  endtask

  task take_rx(input logic [7:0] b);
    int i;
    if (rx_cnt < 4) begin
      frame[rx_cnt] = b;
      rx_cnt++;
    end else begin
      // fifth byte closes the frame, good or not
      if (frame[0] == FRAME_START && frame[3] == ~frame[2] && b == FRAME_END &&
          frame[1] >= 8'd1 && frame[1] <= NUM_SLAVES)
        live[int'(frame[1]) - 1] = 1'b1;
      for (i = 0; i < 4; i++) frame[i] = 8'd0;
      rx_cnt = 0;
    end
  endtask

  task take_tick;
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= sub_len) begin
      tick_cnt = 16'd0;
      step_cnt = step_cnt + 16'd1;
      if (step_cnt >= steps_per_burst) begin
        step_cnt = 16'd0;
        queue_burst();
      end
    end
  endtask

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    errors++;
    if (errors <= SHOW_MAX)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  task check_word(input out_word_t got);
    out_word_t want;
    if (tx_q.size() == 0) begin
      errors++;
      if (errors <= SHOW_MAX)
        $display("%0t: unexpected word, expected none, got port %0h byte %0h last %0h",
                 $time, got.port, got.tx_byte, got.last);
    end else begin
      want = tx_q.pop_front();
      if (got.port !== want.port) report("port", want.port, got.port);
      if (got.tx_byte !== want.tx_byte) report("tx_byte", want.tx_byte, got.tx_byte);
      if (got.last !== want.last) report("last", want.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sub_len = SUB_PERIOD_RST;
      steps_per_burst = REPORT_PERIOD_RST;
      top_id = LAST_ID_RST;
      payload = POLL_PAYLOAD_RST;
      tick_cnt = 16'd0;
      step_cnt = 16'd0;
      next_id = POLL_ID_RST;
      rx_cnt = 0;
      for (int i = 0; i < 4; i++) frame[i] = 8'd0;
      live = '0;
      tx_q.delete();
      errors = 0;
    end else begin
      // a word leaving now never stems from an item taken at this same edge
      if (pop && !empty) check_word(result);
      if (push && !full) begin
        if (item.operation == OP_RX) take_rx(item.rx_byte);
        else take_tick();
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SUB_PERIOD:    sub_len = pwdata[15:0];
          REG_REPORT_PERIOD: steps_per_burst = pwdata[15:0];
          REG_LAST_ID:       top_id = pwdata[7:0];
          REG_POLL_PAYLOAD:  payload = pwdata[7:0];
          default: ;
        endcase
      end
    end
    pending = tx_q.size();
  end

endmodule

// ===== sim/slave_polling_frame_master_tb.sv =====
// Stimulus, drain and verdict for the slave polling frame master.
`timescale 1ns / 1ps
module slave_polling_frame_master_tb;
  import spfm_pkg::*;

  localparam int STALL_CYCLES = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int QUIET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 20;

  logic              clk, rst, push, full, empty, pop;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  in_word_t          item;
  out_word_t         result;
  int                errors, pending, idle_cycles, rx_phase;
  bit                calm;
  int                stall_reqs, stall_done;

  slave_polling_frame_master #(.NUM_SLAVES(NUM_SLAVES_DEF)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  spfm_tx_check #(.NUM_SLAVES(NUM_SLAVES_DEF)) tx_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // nothing moving for too long means the block hung
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable && pwrite && pready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random pop gaps, plus one long hold-off on request
  initial begin : drain
    int gap, k;
    pop <= 1'b0;
    forever begin
      if (stall_done != stall_reqs) begin
        pop <= 1'b0;
        for (k = 0; k < STALL_CYCLES; k++) @(posedge clk);
        stall_done++;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          pop <= 1'b1;
          @(posedge clk);
        end else begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  task send_word(input logic op, input logic [7:0] b);
    int gap;
    push <= 1'b1;
    item <= {op, b};
    do @(posedge clk); while (full);
    if (op == OP_RX) rx_phase = (rx_phase + 1) % 5;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // corrupt < 0 sends a clean frame, else that byte gets flipped
  task send_frame(input logic [7:0] id, input logic [7:0] data, input int corrupt);
    logic [7:0] fb [5];
    logic [7:0] flip;
    int k;
    while (rx_phase != 0) send_word(OP_RX, 8'($urandom_range(0, 255)));
    fb[0] = FRAME_START;
    fb[1] = id;
    fb[2] = data;
    fb[3] = ~data;
    fb[4] = FRAME_END;
    if (corrupt >= 0) begin
      flip = 8'($urandom_range(1, 255));
      fb[corrupt] = fb[corrupt] ^ flip;
    end
    for (k = 0; k < 5; k++) send_word(OP_RX, fb[k]);
  endtask

  task write_reg(input logic [1:0] idx, input logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // hold input until every predicted word is out, then leave the inputs quiet
  task settle;
    if (push) push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  initial begin : stim
    int ph, n, r;
    logic [7:0] id;
    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    calm = 1'b0;
    rx_phase = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset periods: ticks only count up
    repeat (3) send_word(OP_TICK, 8'h00);
    send_frame(8'd2, 8'h5A, -1);
    send_frame(8'd1, 8'h33, 3);

    // zero periods: every tick bursts, poll id wraps after 2
    settle;
    write_reg(REG_SUB_PERIOD, 16'd0);
    write_reg(REG_REPORT_PERIOD, 16'd0);
    write_reg(REG_LAST_ID, 16'd2);
    write_reg(REG_POLL_PAYLOAD, 16'h00);
    repeat (3) send_word(OP_TICK, 8'hFF);

    // max periods, then lower them, the sub period below the running tick count
    settle;
    write_reg(REG_SUB_PERIOD, 16'hFFFF);
    write_reg(REG_REPORT_PERIOD, 16'hFFFF);
    write_reg(REG_LAST_ID, 16'd0);
    write_reg(REG_POLL_PAYLOAD, 16'hFF);
    repeat (4) send_word(OP_TICK, 8'h00);
    settle;
    write_reg(REG_SUB_PERIOD, 16'd1);
    write_reg(REG_REPORT_PERIOD, 16'd1);
    repeat (2) send_word(OP_TICK, 8'hAA);

    // last id 255: poll id keeps counting up without going back to 1
    settle;
    write_reg(REG_SUB_PERIOD, 16'd0);
    write_reg(REG_REPORT_PERIOD, 16'd0);
    write_reg(REG_LAST_ID, 16'd255);
    write_reg(REG_POLL_PAYLOAD, 16'($urandom_range(0, 255)));
    repeat (6) send_word(OP_TICK, 8'($urandom_range(0, 255)));

    for (ph = 0; ph < 5; ph++) begin
      settle;
      calm = (ph == 1);
      write_reg(REG_SUB_PERIOD, (ph == 2) ? 16'd0 : 16'($urandom_range(0, 3)));
      write_reg(REG_REPORT_PERIOD, (ph == 2) ? 16'd0 : 16'($urandom_range(0, 3)));
      r = $urandom_range(0, 9);
      write_reg(REG_LAST_ID, (r == 0) ? 16'd255 : 16'($urandom_range(0, NUM_SLAVES_DEF + 2)));
      write_reg(REG_POLL_PAYLOAD, 16'($urandom_range(0, 255)));
      if (ph == 2) begin
        // result side holds off while bursts pile up and full rises
        stall_reqs++;
        repeat (8) send_word(OP_TICK, 8'($urandom_range(0, 255)));
        settle;
      end
      n = 0;
      while (n < 14) begin
        r = $urandom_range(0, 99);
        id = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, NUM_SLAVES_DEF))
                                          : 8'($urandom_range(0, 255));
        if (r < 45) begin
          send_frame(id, 8'($urandom_range(0, 255)), -1);
          n += 5;
        end else if (r < 55) begin
          send_frame(id, 8'($urandom_range(0, 255)), $urandom_range(0, 4));
          n += 5;
        end else if (r < 65) begin
          send_word(OP_RX, 8'($urandom_range(0, 255)));
          n++;
        end else begin
          send_word(OP_TICK, 8'($urandom_range(0, 255)));
          n++;
        end
      end
    end
    calm = 1'b0;

    settle;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
